/* rtl/lss_pkg.sv */
// Shared types and constants for the five-point Laplacian smoothing stencil.
// Used by every module of the block but lss_line_ram; depends on nothing else.
package lss_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEFF_W   = 16;
   localparam int FRAC_BITS = 12;
   localparam int CFG_W     = 11;
   localparam int TOT_W     = 22;
   localparam int FED_W     = 21;
   localparam int OUT_POS_W = 10;
   localparam int MAX_ROWS  = 1024;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_DATA_W = 40;

   localparam logic [FED_W-1:0]   FED_MAX     = 21'h1F_FFFF;
   localparam logic [CFG_W-1:0]   ROWS_RESET  = 11'd6;
   localparam logic [CFG_W-1:0]   COLS_RESET  = 11'd6;
   localparam logic [TOT_W-1:0]   TOTAL_RESET = 22'd36;
   localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd4915;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEFF    = 2'd2;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  sample;
      logic                 emit;
      logic                 border;
      logic                 last;
      logic [OUT_POS_W-1:0] row;
      logic [OUT_POS_W-1:0] col;
   } lss_tag_type;

endpackage

/* rtl/lss_line_ram.sv */
// Simple dual-port line buffer memory, one write and one registered read port.
// Depends on nothing; used by lss_datapath.
module lss_line_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lss_ctrl.sv */
// Configuration registers and raster position bookkeeping of the stencil.
// Depends on lss_pkg; feeds an item tag and line buffer index to lss_datapath.
module lss_ctrl #(
   parameter int MAX_COLS = 1024,
   parameter int COL_W    = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lss_pkg::COEFF_W-1:0]      csr_wdata,
   input  logic                             accept,
   input  logic                             req_drain,
   input  logic [lss_pkg::SAMPLE_W-1:0]     req_sample,
   output logic                             enter,
   output lss_pkg::lss_tag_type             tag,
   output logic [COL_W-1:0]                 idx,
   output logic signed [lss_pkg::COEFF_W-1:0] coeff
);

   localparam int CFG_W  = lss_pkg::CFG_W;
   localparam int TOT_W  = lss_pkg::TOT_W;
   localparam int FED_W  = lss_pkg::FED_W;
   localparam int WIDE_W = ((COL_W > CFG_W) ? COL_W : CFG_W) + 2;

   logic [CFG_W-1:0]            rows_ff, rows_in, cols_ff, cols_in;
   logic [TOT_W-1:0]            total_ff, total_in;
   logic [lss_pkg::COEFF_W-1:0] coeff_ff, coeff_in;
   logic [COL_W-1:0]            in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [TOT_W-1:0]            out_row_ff, out_row_in, emitted_ff, emitted_in;
   logic [FED_W-1:0]            fed_ff, fed_in;

   logic [CFG_W-1:0] cfg_val, rows_clamp, cols_clamp;
   logic             restart, is_sample, ignore, emit, border, last, done;
   logic [COL_W-1:0] ic0, oc0, ic_w, oc_w, ic_n, oc_n;
   logic [TOT_W-1:0] or0, em0, em1, or_n;
   logic [FED_W-1:0] fed0, fed1;
   logic [WIDE_W-1:0] ic_inc, oc_inc, cols_wide;
   logic [lss_pkg::SAMPLE_W-1:0] s;

   always_comb begin
      cfg_val = csr_wdata[CFG_W-1:0];
      if (cfg_val == '0) begin
         rows_clamp = CFG_W'(1);
         cols_clamp = CFG_W'(1);
      end else begin
         rows_clamp = (int'(cfg_val) > lss_pkg::MAX_ROWS) ? CFG_W'(lss_pkg::MAX_ROWS) : cfg_val;
         cols_clamp = (int'(cfg_val) > MAX_COLS) ? CFG_W'(MAX_COLS) : cfg_val;
      end
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      total_in = total_ff;
      coeff_in = coeff_ff;
      if (csr_we) begin
         case (csr_index)
            lss_pkg::REG_NUM_ROWS: begin
               rows_in  = rows_clamp;
               total_in = TOT_W'(rows_clamp) * TOT_W'(cols_ff);
            end
            lss_pkg::REG_NUM_COLS: begin
               cols_in  = cols_clamp;
               total_in = TOT_W'(rows_ff) * TOT_W'(cols_clamp);
            end
            lss_pkg::REG_COEFF: begin
               coeff_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      restart   = (emitted_ff >= total_ff);
      ic0       = restart ? '0 : in_col_ff;
      oc0       = restart ? '0 : out_col_ff;
      or0       = restart ? '0 : out_row_ff;
      em0       = restart ? '0 : emitted_ff;
      fed0      = restart ? '0 : fed_ff;
      is_sample = (TOT_W'(fed0) < total_ff);
      ignore    = is_sample && req_drain;
      s         = is_sample ? req_sample : '0;
      cols_wide = WIDE_W'(cols_ff);

      ic_w   = (WIDE_W'(ic0) >= cols_wide) ? '0 : ic0;
      ic_inc = WIDE_W'(ic_w) + WIDE_W'(1);
      ic_n   = (ic_inc >= cols_wide) ? '0 : ic_inc[COL_W-1:0];
      fed1   = (fed0 < lss_pkg::FED_MAX) ? fed0 + FED_W'(1) : fed0;
      emit   = (TOT_W'(fed1) >= TOT_W'(cols_ff) + TOT_W'(1));

      oc_w   = (WIDE_W'(oc0) >= cols_wide) ? '0 : oc0;
      border = (or0 == '0) || (or0 + TOT_W'(1) >= TOT_W'(rows_ff)) || (oc_w == '0) ||
               (WIDE_W'(oc_w) + WIDE_W'(1) >= cols_wide);
      em1    = em0 + TOT_W'(1);
      last   = (em1 == total_ff);
      done   = (em1 >= total_ff);
      oc_inc = WIDE_W'(oc_w) + WIDE_W'(1);
      if (oc_inc >= cols_wide) begin
         oc_n = '0;
         or_n = or0 + TOT_W'(1);
      end else begin
         oc_n = oc_inc[COL_W-1:0];
         or_n = or0;
      end

      in_col_in  = in_col_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      emitted_in = emitted_ff;
      fed_in     = fed_ff;
      if (accept) begin
         if (ignore) begin
            in_col_in  = ic0;
            out_col_in = oc0;
            out_row_in = or0;
            emitted_in = em0;
            fed_in     = fed0;
         end else if (emit && done) begin
            in_col_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            emitted_in = '0;
            fed_in     = '0;
         end else begin
            in_col_in  = ic_n;
            fed_in     = fed1;
            out_col_in = emit ? oc_n : oc0;
            out_row_in = emit ? or_n : or0;
            emitted_in = emit ? em1 : em0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= lss_pkg::ROWS_RESET;
         cols_ff    <= lss_pkg::COLS_RESET;
         total_ff   <= lss_pkg::TOTAL_RESET;
         coeff_ff   <= lss_pkg::COEFF_RESET;
         in_col_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         emitted_ff <= '0;
         fed_ff     <= '0;
      end else begin
         rows_ff    <= rows_in;
         cols_ff    <= cols_in;
         total_ff   <= total_in;
         coeff_ff   <= coeff_in;
         in_col_ff  <= in_col_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         emitted_ff <= emitted_in;
         fed_ff     <= fed_in;
      end
   end

   assign enter      = accept && !ignore;
   assign idx        = ic_w;
   assign coeff      = $signed(coeff_ff);
   assign tag.sample = s;
   assign tag.emit   = emit;
   assign tag.border = border;
   assign tag.last   = last;
   assign tag.row    = lss_pkg::OUT_POS_W'(or0);
   assign tag.col    = lss_pkg::OUT_POS_W'(oc_w);

   a_in_col_range: assert property (@(posedge clock) disable iff (reset)
      in_col_ff < MAX_COLS) else $error("input column out of range");

   a_out_col_range: assert property (@(posedge clock) disable iff (reset)
      out_col_ff < MAX_COLS) else $error("output column out of range");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      enter && tag.emit && tag.last |=> emitted_ff == '0 && fed_ff == '0)
      else $error("matrix did not restart after its final item");

endmodule

/* rtl/lss_datapath.sv */
// Line buffer access, 3x3 window and fixed-point stencil pipeline with output register.
// Depends on lss_pkg and lss_line_ram; driven by the item tags of lss_ctrl.
module lss_datapath #(
   parameter int MAX_COLS = 1024,
   parameter int COL_W    = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enter,
   input  lss_pkg::lss_tag_type                  tag,
   input  logic [COL_W-1:0]                      idx,
   input  logic signed [lss_pkg::COEFF_W-1:0]    coeff,
   output logic                                  ready,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lss_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int S       = lss_pkg::SAMPLE_W;
   localparam int LAP_W   = S + 3;
   localparam int PROD_W  = lss_pkg::COEFF_W + LAP_W;
   localparam int SUM_W   = PROD_W - lss_pkg::FRAC_BITS + 1;
   localparam int POS_W   = lss_pkg::OUT_POS_W;
   localparam int PAD_W   = lss_pkg::RSP_DATA_W - S - 2 * POS_W;

   logic adv;
   logic [2*S-1:0] rd_entry, wr_entry;
   logic           wr_en;

   logic                 b_valid_ff, b_valid_in;
   lss_pkg::lss_tag_type b_tag_ff;
   logic [COL_W-1:0]     b_idx_ff;
   logic                 fwd_ff, fwd_in;
   logic [2*S-1:0]       fwd_entry_ff;

   logic signed [S-1:0] w02_ff, w11_ff, w12_ff, w22_ff;
   logic signed [S-1:0] la_b, lta_b;

   logic                    c_valid_ff, c_valid_in;
   logic signed [LAP_W-1:0] c_lap_ff, c_lap_in;
   logic signed [S-1:0]     c_center_ff;
   lss_pkg::lss_tag_type    c_tag_ff;

   logic                     d_valid_ff, d_valid_in;
   logic signed [PROD_W-1:0] d_prod_ff, d_prod_in;
   logic signed [S-1:0]      d_center_ff;
   lss_pkg::lss_tag_type     d_tag_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [S-1:0]            value_ff, value_in;
   logic [POS_W-1:0]        row_ff, col_ff;
   logic                    last_ff;
   logic signed [SUM_W-1:0] sum;
   logic                    fits;

   lss_line_ram #(
      .DEPTH (MAX_COLS),
      .ADDR_W(COL_W),
      .DATA_W(2 * S)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(b_idx_ff),
      .wr_data(wr_entry),
      .rd_en  (enter),
      .rd_addr(idx),
      .rd_data(rd_entry)
   );

   assign adv   = !rsp_valid_ff || rsp_tready;
   assign ready = adv;

   always_comb begin
      la_b     = fwd_ff ? $signed(fwd_entry_ff[2*S-1:S]) : $signed(rd_entry[2*S-1:S]);
      lta_b    = fwd_ff ? $signed(fwd_entry_ff[S-1:0]) : $signed(rd_entry[S-1:0]);
      wr_entry = {b_tag_ff.sample, la_b};
      wr_en    = b_valid_ff && adv;
      fwd_in   = adv ? (enter && b_valid_ff && (b_idx_ff == idx)) : fwd_ff;
      b_valid_in = adv ? enter : b_valid_ff;

      c_lap_in = LAP_W'(w02_ff) + LAP_W'(w11_ff) + LAP_W'(la_b) + LAP_W'(w22_ff)
                 - (LAP_W'(w12_ff) <<< 2);
      c_valid_in = adv ? (b_valid_ff && b_tag_ff.emit) : c_valid_ff;

      d_prod_in  = PROD_W'(coeff) * PROD_W'(c_lap_ff);
      d_valid_in = adv ? c_valid_ff : d_valid_ff;

      sum  = SUM_W'(d_center_ff) +
             SUM_W'($signed(d_prod_ff[PROD_W-1:lss_pkg::FRAC_BITS]));
      fits = (&sum[SUM_W-1:S-1]) || !(|sum[SUM_W-1:S-1]);
      if (d_tag_ff.border) begin
         value_in = d_center_ff;
      end else if (fits) begin
         value_in = sum[S-1:0];
      end else begin
         value_in = sum[SUM_W-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
      end
      rsp_valid_in = adv ? d_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         w02_ff       <= '0;
         w11_ff       <= '0;
         w12_ff       <= '0;
         w22_ff       <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         fwd_ff       <= fwd_in;
         c_valid_ff   <= c_valid_in;
         d_valid_ff   <= d_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            w11_ff <= w12_ff;
            w02_ff <= lta_b;
            w12_ff <= la_b;
            w22_ff <= $signed(b_tag_ff.sample);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enter) begin
         b_tag_ff     <= tag;
         b_idx_ff     <= idx;
         fwd_entry_ff <= wr_entry;
      end
      if (adv) begin
         c_lap_ff    <= c_lap_in;
         c_center_ff <= w12_ff;
         c_tag_ff    <= b_tag_ff;
         d_prod_ff   <= d_prod_in;
         d_center_ff <= c_center_ff;
         d_tag_ff    <= c_tag_ff;
      end
      if (adv && d_valid_ff) begin
         value_ff <= value_in;
         row_ff   <= d_tag_ff.row;
         col_ff   <= d_tag_ff.col;
         last_ff  <= d_tag_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, col_ff, row_ff, value_ff};
   assign rsp_tlast  = last_ff;

   a_enter_fills_b: assert property (@(posedge clock) disable iff (reset)
      enter |=> b_valid_ff) else $error("entered item missing from read stage");

   a_fwd_needs_item: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> b_valid_ff) else $error("forwarding without an item in read stage");

endmodule

/* rtl/laplacian_smoothing_stencil.sv */
// Five-point Laplacian smoothing stencil over a raster-order sample stream.
// Items enter on the req_ channel: tdata carries one signed sample, tuser
// marks a drain item that flushes one pending result after the last sample.
// Each inner point gives center + c*(up + left + right + down - 4*center),
// with c in signed Q3.12, floored and saturated; border points pass through.
// The rsp_ channel carries value, row and column in tdata and marks the
// final element of the matrix with tlast.
// The result for a position is produced by the item num_cols+1 later in the
// stream and passes the read, Laplacian and product stages into the output
// register. One item is accepted every cycle unless the receiver stalls; the
// line buffer has separate read and write ports, and forwarding between
// consecutive items at the same column sustains that rate at any line length.
// Reset restores num_rows = 6, num_cols = 6, coeff = 4915 and clears the
// position counters and window; line buffer contents are not cleared.
// When the receiver stalls, the result stays in the output register and
// req_tready drops until it is taken. The user writes num_rows, num_cols and
// coeff on csr_ only while the block is idle; the block does not enforce it.
module laplacian_smoothing_stencil #(
   parameter int MAX_COLS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lss_pkg::SAMPLE_W-1:0]        req_tdata,  // sample
   input  logic [0:0]                          req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lss_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // value, out_row, out_col
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [lss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lss_pkg::COEFF_W-1:0]         csr_wdata
);

   localparam int COL_W = $clog2(MAX_COLS);

   logic                                 accept, enter;
   lss_pkg::lss_tag_type                 tag;
   logic [COL_W-1:0]                     idx;
   logic signed [lss_pkg::COEFF_W-1:0]   coeff;

   assign accept = req_tvalid && req_tready;

   lss_ctrl #(
      .MAX_COLS(MAX_COLS),
      .COL_W   (COL_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_drain (req_tuser[0]),
      .req_sample(req_tdata),
      .enter     (enter),
      .tag       (tag),
      .idx       (idx),
      .coeff     (coeff)
   );

   lss_datapath #(
      .MAX_COLS(MAX_COLS),
      .COL_W   (COL_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .enter     (enter),
      .tag       (tag),
      .idx       (idx),
      .coeff     (coeff),
      .ready     (req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

/* sim/tb_laplacian_smoothing_stencil.sv */
// Self-checking testbench for laplacian_smoothing_stencil: streams sample matrices and
// drain items, predicts every smoothed result and compares it with the rsp_ channel.
// Depends on rtl/lss_pkg.sv and rtl/laplacian_smoothing_stencil.sv.
`timescale 1ns / 100ps

module tb_laplacian_smoothing_stencil;

   localparam int LINE_DEPTH    = 1024;
   localparam int RUN_LIMIT     = 600000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 1000;

   typedef struct packed {
      bit          drain;
      logic [15:0] sample;
   } stream_item_type;

   typedef struct packed {
      logic [15:0] value;
      logic [9:0]  row;
      logic [9:0]  col;
      logic        last;
   } smoothed_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [lss_pkg::SAMPLE_W-1:0]   req_tdata = '0;
   logic [0:0]                     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [lss_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_we = 1'b0;
   logic [lss_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [lss_pkg::COEFF_W-1:0]    csr_wdata = '0;

   stream_item_type stream_items[$];
   smoothed_type    smoothed_due[$];
   bit              item_taken = 1'b0;
   int              mismatches = 0;
   int unsigned     cycle_count = 0;
   int unsigned     send_idle_pct = 19;
   int unsigned     recv_stall_pct = 73;

   logic [lss_pkg::CFG_W-1:0]          rows_reg;
   logic [lss_pkg::CFG_W-1:0]          cols_reg;
   logic signed [lss_pkg::COEFF_W-1:0] coeff_reg;
   logic signed [15:0]                 line_above_q [LINE_DEPTH];
   logic signed [15:0]                 line_two_above_q [LINE_DEPTH];
   logic signed [15:0]                 win [3][3];
   int unsigned                        in_col_q, emitted_q, fed_q, out_r_q, out_c_q;

   laplacian_smoothing_stencil dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(logic [lss_pkg::CFG_W-1:0] v);
      if (v == 0) return 1;
      return (v > LINE_DEPTH) ? LINE_DEPTH : int'(v);
   endfunction

   function automatic void restart_matrix();
      in_col_q = 0;
      emitted_q = 0;
      fed_q = 0;
      out_r_q = 0;
      out_c_q = 0;
   endfunction

   function automatic bit predict_smoothed(input bit drain, input logic signed [15:0] smp,
                                           output smoothed_type res);
      int unsigned rows, cols, total, idx;
      int          r;
      bit          is_sample;
      logic signed [15:0] s, center;
      longint      lap, acc;
      rows = clamp_dim(rows_reg);
      cols = clamp_dim(cols_reg);
      total = rows * cols;
      res = '0;
      if (emitted_q >= total) restart_matrix();
      is_sample = fed_q < total;
      if (is_sample && drain) return 1'b0;
      s = is_sample ? smp : 16'sd0;
      if (in_col_q >= cols) in_col_q = 0;
      idx = in_col_q;
      for (r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = line_two_above_q[idx];
      win[1][2] = line_above_q[idx];
      win[2][2] = s;
      line_two_above_q[idx] = line_above_q[idx];
      line_above_q[idx] = s;
      in_col_q++;
      if (in_col_q >= cols) in_col_q = 0;
      if (fed_q < lss_pkg::FED_MAX) fed_q++;
      if (fed_q < cols + 1) return 1'b0;

      if (out_c_q >= cols) out_c_q = 0;
      center = win[1][1];
      if (out_r_q == 0 || out_r_q + 1 >= rows || out_c_q == 0 || out_c_q + 1 >= cols) begin
         acc = center;
      end else begin
         lap = longint'(win[0][1]) + longint'(win[1][0]) + longint'(win[1][2])
               + longint'(win[2][1]) - 4 * longint'(center);
         acc = (longint'(center) * 4096 + longint'(coeff_reg) * lap) >>> lss_pkg::FRAC_BITS;
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
      end
      res.value = acc[15:0];
      res.row   = out_r_q[9:0];
      res.col   = out_c_q[9:0];
      res.last  = (emitted_q + 1 == total);
      emitted_q++;
      out_c_q++;
      if (out_c_q >= cols) begin
         out_c_q = 0;
         out_r_q++;
      end
      if (emitted_q >= total) restart_matrix();
      return 1'b1;
   endfunction

   always @(posedge clock) begin : monitor
      smoothed_type got, want, pred;
      int           i;
      if (reset) begin
         item_taken = 1'b0;
         rows_reg = lss_pkg::ROWS_RESET;
         cols_reg = lss_pkg::COLS_RESET;
         coeff_reg = lss_pkg::COEFF_RESET;
         for (i = 0; i < LINE_DEPTH; i++) begin
            line_above_q[i] = '0;
            line_two_above_q[i] = '0;
         end
         for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
         restart_matrix();
      end else begin
         item_taken = req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[15:0];
            got.row   = rsp_tdata[25:16];
            got.col   = rsp_tdata[35:26];
            got.last  = rsp_tlast;
            if (smoothed_due.size() == 0) begin
               $error("unexpected result item at row %0d col %0d", got.row, got.col);
               mismatches++;
            end else begin
               want = smoothed_due.pop_front();
               if (got.value !== want.value) begin
                  $error("value: expected %0d, got %0d", $signed(want.value), $signed(got.value));
                  mismatches++;
               end
               if (got.row !== want.row) begin
                  $error("out_row: expected %0d, got %0d", want.row, got.row);
                  mismatches++;
               end
               if (got.col !== want.col) begin
                  $error("out_col: expected %0d, got %0d", want.col, got.col);
                  mismatches++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got.last);
                  mismatches++;
               end
            end
         end
         if (item_taken && predict_smoothed(req_tuser[0], $signed(req_tdata), pred))
            smoothed_due.push_back(pred);
         if (csr_we) begin
            case (csr_index)
               lss_pkg::REG_NUM_ROWS: rows_reg = csr_wdata[lss_pkg::CFG_W-1:0];
               lss_pkg::REG_NUM_COLS: cols_reg = csr_wdata[lss_pkg::CFG_W-1:0];
               lss_pkg::REG_COEFF:    coeff_reg = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always @(negedge clock) begin : drive_req
      stream_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || item_taken) begin
         if (stream_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = stream_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= item.sample;
            req_tuser <= item.drain;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic void queue_item(bit drain, logic [15:0] smp);
      stream_items.push_back('{drain, smp});
   endfunction

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (stream_items.size() != 0 || req_tvalid || smoothed_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [lss_pkg::CFG_W-1:0] rows, logic [lss_pkg::CFG_W-1:0] cols,
                            logic [lss_pkg::COEFF_W-1:0] c);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= lss_pkg::REG_NUM_ROWS;
      csr_wdata <= lss_pkg::COEFF_W'(rows);
      @(negedge clock);
      csr_index <= lss_pkg::REG_NUM_COLS;
      csr_wdata <= lss_pkg::COEFF_W'(cols);
      @(negedge clock);
      csr_index <= lss_pkg::REG_COEFF;
      csr_wdata <= c;
      @(negedge clock);
      csr_we <= 1'b0;
      #1;
   endtask

   // A 3x3 matrix with one inner point, followed by an extra sample and three drains.
   task automatic feed_plus(logic [15:0] center, logic [15:0] around);
      int n;
      for (n = 0; n < 9; n++) queue_item(1'b0, (n == 4) ? center : around);
      queue_item(1'b0, around);
      repeat (3) queue_item(1'b1, 16'($urandom));
   endtask

   task automatic feed_matrix(int unsigned rows, int unsigned cols, int flavor, bit noisy);
      int unsigned n;
      logic [15:0] v;
      for (n = 0; n < rows * cols; n++) begin
         if (noisy && $urandom_range(19) == 0) queue_item(1'b1, 16'($urandom));
         case (flavor)
            0: v = 16'($urandom);
            1: v = ($urandom_range(1) == 0) ? 16'h7FFF : 16'h8000;
            default: v = 16'($signed($urandom_range(64)) - 32);
         endcase
         queue_item(1'b0, v);
      end
      // Flush items; in noisy matrices some are samples past the end, which act as drains.
      for (n = 0; n <= cols; n++)
         queue_item((noisy && $urandom_range(3) == 0) ? 1'b0 : 1'b1, 16'($urandom));
      if (noisy && $urandom_range(4) == 0) queue_item(1'b1, 16'($urandom));
   endtask

   function automatic logic [lss_pkg::COEFF_W-1:0] pick_coeff();
      case ($urandom_range(4))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom);
         default: return 16'($urandom_range(8192));
      endcase
   endfunction

   initial begin
      int unsigned random_items, rows_w, cols_w, rows, cols;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(11'd3, 11'd3, 16'h7FFF);
      queue_item(1'b1, 16'hFFFF);
      feed_plus(16'h8000, 16'h7FFF);
      configure(11'd3, 11'd3, 16'h8000);
      feed_plus(16'h0000, 16'h7FFF);

      configure(11'd0, 11'd0, pick_coeff());
      feed_matrix(1, 1, 0, 1'b0);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         rows_w = $urandom_range(9);
         cols_w = $urandom_range(12);
         rows = (rows_w == 0) ? 1 : rows_w;
         cols = (cols_w == 0) ? 1 : cols_w;
         configure(lss_pkg::CFG_W'(rows_w), lss_pkg::CFG_W'(cols_w), pick_coeff());
         if (random_items < RANDOM_ITEMS / 3) begin
            send_idle_pct = 19;
            recv_stall_pct = 73;
         end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 73;
            recv_stall_pct = 19;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         repeat ($urandom_range(3, 1)) begin
            feed_matrix(rows, cols, $urandom_range(2), $urandom_range(2) == 0);
            random_items += rows * cols + cols + 1;
         end
      end

      wait_idle();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
rtl/lss_pkg.sv
rtl/lss_line_ram.sv
rtl/lss_ctrl.sv
rtl/lss_datapath.sv
rtl/laplacian_smoothing_stencil.sv
sim/tb_laplacian_smoothing_stencil.sv
